// ===== rtl/odhm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package odhm_pkg;

   localparam int DEG_W      = 9;
   localparam int SPEED_W    = 11;
   localparam int DUTY_W     = 12;
   localparam int ERR_W      = 8;
   localparam int IDX_W      = 7;
   localparam int KD_W       = 20;
   localparam int CORR_W     = 20;
   localparam int WHEEL_W    = 21;
   localparam int WHEELS     = 4;

   localparam int SINE_ENTRIES = 91;

   localparam logic [DEG_W-1:0] DEG_1   = 9'd1;
   localparam logic [DEG_W-1:0] DEG_45  = 9'd45;
   localparam logic [DEG_W-1:0] DEG_90  = 9'd90;
   localparam logic [DEG_W-1:0] DEG_180 = 9'd180;
   localparam logic [DEG_W-1:0] DEG_270 = 9'd270;
   localparam logic [DEG_W-1:0] DEG_359 = 9'd359;
   localparam logic [DEG_W-1:0] DEG_360 = 9'd360;

   localparam logic [DUTY_W-1:0] ROTATE_LIMIT_RESET = 12'd1800;

   // floor(x / 60) for 12-bit x as (x * 4370) >> 18
   localparam int                RECIP60_W     = 13;
   localparam logic [12:0]       RECIP60       = 13'd4370;
   localparam int                RECIP60_SHIFT = 18;
   localparam int                KP_GAIN_W     = 7;

   localparam logic signed [9:0] D_GAIN = 10'sd500;

   localparam logic [63:0] RAD_PER_DEG_Q30 = 64'd18740330;
   localparam logic [63:0] TAYLOR_DEN [0:6] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                64'd110, 64'd156, 64'd210};

   // subtract mask per wheel, bit 0 is wheel one
   localparam logic [WHEELS-1:0] MIX_PNNP = 4'b0110;
   localparam logic [WHEELS-1:0] MIX_NPPN = 4'b1001;
   localparam logic [WHEELS-1:0] MIX_NNPP = 4'b0011;
   localparam logic [WHEELS-1:0] MIX_PPNN = 4'b1100;

   typedef struct packed {
      logic [DEG_W-1:0]   heading_deg;
      logic [SPEED_W-1:0] speed;
      logic [DEG_W-1:0]   yaw_deg;
   } req_beat_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_one;
      logic [DUTY_W-1:0] duty_two;
      logic [DUTY_W-1:0] duty_three;
      logic [DUTY_W-1:0] duty_four;
      logic              dir_one;
      logic              dir_two;
      logic              dir_three;
      logic              dir_four;
   } rsp_beat_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic trig;
      logic mul;
      logic div_step;
      logic mix;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

   // series sine in q30 of a whole degree 0..90, elaboration only
   function automatic logic [63:0] sine_q30(input int unsigned deg);
      logic [63:0] r;
      logic [63:0] r2;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      r    = 64'(deg) * RAD_PER_DEG_Q30;
      r2   = (r * r) >> 30;
      term = r;
      pos  = r;
      neg  = '0;
      for (int k = 0; k < 7; k++) begin
         term = ((term * r2) >> 30) / TAYLOR_DEN[k];
         if (k % 2 == 0) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      return (pos > neg) ? pos - neg : 64'd0;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/odhm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module odhm_ctrl import odhm_pkg::*; #(
   parameter int DIV_STEPS = 27
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam int CNT_W = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_TRIG,
      ST_MUL,
      ST_DIV,
      ST_MIX
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP: state_in = ST_TRIG;
         ST_TRIG: state_in = ST_MUL;
         ST_MUL: begin
            state_in = ST_DIV;
            cnt_in   = '0;
         end
         ST_DIV: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_MIX;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MIX: begin
            if (!status.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == ST_IDLE) && req_valid;
      cmd.prep     = (state_ff == ST_PREP);
      cmd.trig     = (state_ff == ST_TRIG);
      cmd.mul      = (state_ff == ST_MUL);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.mix      = (state_ff == ST_MIX) && !status.out_busy;
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_PREP)
      else $error("accepted beat did not start prep");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && cnt_ff == CNT_LAST |=> state_ff == ST_MIX)
      else $error("divider ran past its step count");

   a_mix_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MIX && status.out_busy |=> state_ff == ST_MIX)
      else $error("result dropped while output still held");
`endif

endmodule

`default_nettype wire

// ===== rtl/odhm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module odhm_datapath import odhm_pkg::*; #(
   parameter int TRIG_FRAC_BITS = 15
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output status_type               status,
   input  wire req_beat_type        req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_beat_type             rsp_data,
   input  wire logic                csr_wr_en,
   input  wire logic [DUTY_W-1:0]   csr_wr_data
);

   localparam int DW    = TRIG_FRAC_BITS + 1;
   localparam int PW    = DW + SPEED_W;
   localparam int SHIFT = 30 - TRIG_FRAC_BITS;

   function automatic logic [SINE_ENTRIES*DW-1:0] sine_rom();
      logic [SINE_ENTRIES*DW-1:0] rom;
      logic [63:0]                s;
      rom = '0;
      for (int d = 0; d < SINE_ENTRIES; d++) begin
         s = sine_q30(d);
         s = (s + (64'd1 << (SHIFT - 1))) >> SHIFT;
         rom[d*DW +: DW] = s[DW-1:0];
      end
      return rom;
   endfunction

   localparam logic [SINE_ENTRIES*DW-1:0] SINE_ROM = sine_rom();

   // control and architectural state
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]    rl_ff, rl_in;
   logic [ERR_W-1:0]     prev_err_ff, prev_err_in;

   // item registers
   logic [DEG_W-1:0]         h_ff, h_in;
   logic [SPEED_W-1:0]       v_ff, v_in;
   logic [DEG_W-1:0]         g_ff, g_in;
   logic [IDX_W-1:0]         si_ff, si_in;
   logic [IDX_W-1:0]         ci_ff, ci_in;
   logic                     cneg_ff, cneg_in;
   logic                     sneg_ff, sneg_in;
   logic [ERR_W-1:0]         err_ff, err_in;
   logic                     mix_en_ff, mix_en_in;
   logic [WHEELS-1:0]        mix_neg_ff, mix_neg_in;
   logic [KP_GAIN_W-1:0]     kp_gain_ff, kp_gain_in;
   logic [DW-1:0]            sm_ff, sm_in;
   logic [DW-1:0]            cm_ff, cm_in;
   logic [ERR_W+KP_GAIN_W-1:0] kp_raw_ff, kp_raw_in;
   logic signed [KD_W-1:0]   kd_ff, kd_in;
   logic                     swap_ff, swap_in;
   logic [DW-1:0]            den_ff, den_in;
   logic [DW-1:0]            rem_ff, rem_in;
   logic [PW-1:0]            quo_ff, quo_in;
   logic signed [CORR_W-1:0] corr_ff, corr_in;
   rsp_beat_type             rsp_ff, rsp_in;

   // prep
   logic [DEG_W-1:0] h_fix, a2_sum, a2, a, g_fix;
   logic             q0, q1, q2, q3, ya, yb;
   logic [RECIP60_W+DUTY_W-1:0] rl_prod;

   always_comb begin
      h_fix  = (h_ff > DEG_360) ? h_ff - DEG_360 : h_ff;
      a2_sum = h_fix + DEG_45;
      a2     = (a2_sum > DEG_360) ? a2_sum - DEG_360 : a2_sum;
      a      = (a2 == DEG_360) ? '0 : a2;
      g_fix  = (g_ff >= DEG_360) ? g_ff - DEG_360 : g_ff;

      if (a <= DEG_90) begin
         si_in = IDX_W'(a);
         ci_in = IDX_W'(DEG_90 - a);
         sneg_in = 1'b0;
         cneg_in = 1'b0;
      end else if (a <= DEG_180) begin
         si_in = IDX_W'(DEG_180 - a);
         ci_in = IDX_W'(a - DEG_90);
         sneg_in = 1'b0;
         cneg_in = 1'b1;
      end else if (a <= DEG_270) begin
         si_in = IDX_W'(a - DEG_180);
         ci_in = IDX_W'(DEG_270 - a);
         sneg_in = 1'b1;
         cneg_in = 1'b1;
      end else begin
         si_in = IDX_W'(DEG_360 - a);
         ci_in = IDX_W'(a - DEG_270);
         sneg_in = 1'b1;
         cneg_in = 1'b0;
      end

      err_in = (g_fix < DEG_180) ? ERR_W'(g_fix) : ERR_W'(DEG_360 - g_fix);

      q0 = (a2 <= DEG_90);
      q1 = !q0 && (a2 <= DEG_180);
      q2 = !q0 && !q1 && (a2 <= DEG_270);
      q3 = (a2 > DEG_270);
      ya = (g_fix > DEG_1) && (g_fix <= DEG_180);
      yb = (g_fix > DEG_180) && (g_fix < DEG_359);
      mix_en_in = ya || yb;
      if ((q0 && ya) || (q2 && yb)) begin
         mix_neg_in = MIX_PNNP;
      end else if ((q0 && yb) || (q2 && ya)) begin
         mix_neg_in = MIX_NPPN;
      end else if ((q1 && ya) || (q3 && yb)) begin
         mix_neg_in = MIX_NNPP;
      end else begin
         mix_neg_in = MIX_PPNN;
      end

      rl_prod    = (RECIP60_W+DUTY_W)'(rl_ff) * (RECIP60_W+DUTY_W)'(RECIP60);
      kp_gain_in = rl_prod[RECIP60_SHIFT +: KP_GAIN_W];
   end

   // table lookup and pd terms
   logic signed [ERR_W+1:0] err_diff;
   logic signed [KD_W-1:0]  kd_full;

   always_comb begin
      sm_in     = SINE_ROM[si_ff*DW +: DW];
      cm_in     = SINE_ROM[ci_ff*DW +: DW];
      kp_raw_in = (ERR_W+KP_GAIN_W)'(err_ff) * (ERR_W+KP_GAIN_W)'(kp_gain_ff);
      err_diff  = $signed({2'b00, err_ff}) - $signed({2'b00, prev_err_ff});
      kd_full   = KD_W'(err_diff) * KD_W'(D_GAIN);
      kd_in     = (kd_full > $signed({(KD_W-DUTY_W)'(0), rl_ff}))
                  ? $signed({(KD_W-DUTY_W)'(0), rl_ff}) : kd_full;
   end

   // multiply setup and pd sum
   logic [DW-1:0]     min_mag;
   logic [DUTY_W-1:0] kp_c;

   always_comb begin
      swap_in = (cm_ff < sm_ff);
      min_mag = swap_in ? cm_ff : sm_ff;
      den_in  = swap_in ? sm_ff : cm_ff;
      kp_c    = (kp_raw_ff > (ERR_W+KP_GAIN_W)'(rl_ff)) ? rl_ff : DUTY_W'(kp_raw_ff);
      corr_in = $signed({(CORR_W-DUTY_W)'(0), kp_c}) + CORR_W'(kd_ff);
   end

   // one quotient bit per step
   logic [DW:0] div_trial;
   logic [DW:0] div_diff;

   always_comb begin
      div_trial = {rem_ff, quo_ff[PW-1]};
      div_diff  = div_trial - {1'b0, den_ff};
   end

   // wheel mix
   logic [SPEED_W-1:0]        small_base, base13, base24;
   logic signed [WHEEL_W-1:0] wheel_p [WHEELS];
   logic [WHEEL_W-1:0]        wheel_m [WHEELS];
   logic [DUTY_W-1:0]         duty [WHEELS];
   logic [WHEELS-1:0]         flag;
   logic                      cneg_eff, sneg_eff;

   always_comb begin
      small_base = (den_ff == '0) ? '0 : quo_ff[SPEED_W-1:0];
      base13     = swap_ff ? small_base : v_ff;
      base24     = swap_ff ? v_ff : small_base;
      cneg_eff   = cneg_ff && (cm_ff != '0);
      sneg_eff   = sneg_ff && (sm_ff != '0);
      for (int i = 0; i < WHEELS; i++) begin
         wheel_p[i] = $signed({(WHEEL_W-SPEED_W)'(0), ((i % 2 == 0) ? base13 : base24)});
         if (mix_en_ff) begin
            if (mix_neg_ff[i]) begin
               wheel_p[i] = wheel_p[i] - WHEEL_W'(corr_ff);
            end else begin
               wheel_p[i] = wheel_p[i] + WHEEL_W'(corr_ff);
            end
         end
         flag[i]    = wheel_p[i][WHEEL_W-1];
         wheel_m[i] = flag[i] ? WHEEL_W'(-wheel_p[i]) : WHEEL_W'(wheel_p[i]);
         duty[i]    = (wheel_m[i] > WHEEL_W'(rl_ff)) ? rl_ff : DUTY_W'(wheel_m[i]);
      end
      rsp_in.duty_one   = duty[0];
      rsp_in.duty_two   = duty[1];
      rsp_in.duty_three = duty[2];
      rsp_in.duty_four  = duty[3];
      rsp_in.dir_one    = ~(flag[0] ^ cneg_eff);
      rsp_in.dir_two    = flag[1] ^ sneg_eff;
      rsp_in.dir_three  = flag[2] ^ cneg_eff;
      rsp_in.dir_four   = flag[3] ^ sneg_eff;
   end

   always_comb begin
      h_in = req_data.heading_deg;
      v_in = req_data.speed;
      g_in = req_data.yaw_deg;
      if (cmd.mul) begin
         rem_in = '0;
         quo_in = PW'(min_mag) * PW'(v_ff);
      end else begin
         rem_in = div_diff[DW] ? div_trial[DW-1:0] : div_diff[DW-1:0];
         quo_in = {quo_ff[PW-2:0], ~div_diff[DW]};
      end
      rl_in        = csr_wr_en ? csr_wr_data : rl_ff;
      prev_err_in  = cmd.mix ? err_ff : prev_err_ff;
      rsp_valid_in = cmd.mix ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rl_ff        <= ROTATE_LIMIT_RESET;
         prev_err_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rl_ff        <= rl_in;
         prev_err_ff  <= prev_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         h_ff <= h_in;
         v_ff <= v_in;
         g_ff <= g_in;
      end
      if (cmd.prep) begin
         si_ff      <= si_in;
         ci_ff      <= ci_in;
         cneg_ff    <= cneg_in;
         sneg_ff    <= sneg_in;
         err_ff     <= err_in;
         mix_en_ff  <= mix_en_in;
         mix_neg_ff <= mix_neg_in;
         kp_gain_ff <= kp_gain_in;
      end
      if (cmd.trig) begin
         sm_ff     <= sm_in;
         cm_ff     <= cm_in;
         kp_raw_ff <= kp_raw_in;
         kd_ff     <= kd_in;
      end
      if (cmd.mul) begin
         swap_ff <= swap_in;
         den_ff  <= den_in;
         corr_ff <= corr_in;
      end
      if (cmd.mul || cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.mix) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

`ifndef SYNTHESIS
   a_mix_shows_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.mix |=> rsp_valid_ff)
      else $error("result beat not presented after mix");
`endif

endmodule

`default_nettype wire

// ===== rtl/omni_drive_heading_mixer.sv =====
// each req beat runs prep, trig, mul, the divider and mix before another req beat is taken
// the one-bit-per-cycle restoring divider scales the smaller wheel base
//   (TRIG_FRAC_BITS + 12 steps)
// a new req beat is taken while the previous rsp beat still waits in the output register
// reset is synchronous, active high: rotate limit returns to 1800, stored heading error to 0
`timescale 1ns / 1ps
`default_nettype none

module omni_drive_heading_mixer import odhm_pkg::*; #(
   parameter int TRIG_FRAC_BITS = 15
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_beat_type      req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_beat_type           rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [DUTY_W-1:0] csr_wr_data
);

   localparam int DIV_STEPS = TRIG_FRAC_BITS + 1 + SPEED_W;

   cmd_type    cmd;
   status_type status;

   odhm_ctrl #(
      .DIV_STEPS (DIV_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   odhm_datapath #(
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule

`default_nettype wire

// ===== tb/omni_drive_heading_mixer_tb.sv =====
`timescale 1ns / 1ps

module omni_drive_heading_mixer_tb;
   import odhm_pkg::*;

   localparam int TRIG_FRAC_BITS = 15;
   localparam int SINE_SHIFT     = 30 - TRIG_FRAC_BITS;
   localparam longint unsigned DEG_TO_RAD_Q30 = 64'd18740330;
   localparam int HEADING_D_GAIN = 500;
   localparam int P_SPLIT        = 60;
   localparam int HOLD_CYCLES    = 400;
   localparam int QUIET_LIMIT    = 4000;
   localparam int TAIL_CYCLES    = 64;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_beat_type      req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_beat_type      rsp_data;
   logic              csr_wr_en = 1'b0;
   logic [DUTY_W-1:0] csr_wr_data = '0;

   rsp_beat_type pending_wheel_cmds [$];
   rsp_beat_type want_cmd;
   int unsigned  duty_ceiling = 1800;
   int unsigned  last_heading_err = 0;
   int           fail_count = 0;
   int           quiet_cycles = 0;
   int           ready_gap = 0;
   bit           idle_en = 1'b1;
   bit           hold_off = 1'b0;
   event         long_hold_start;

   omni_drive_heading_mixer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // series sine of a whole degree 0..90, rounded to the trig fraction
   function automatic int unsigned quarter_sine(input int unsigned deg);
      longint unsigned r;
      longint unsigned r2;
      longint unsigned term;
      longint unsigned pos;
      longint unsigned neg;
      longint unsigned s;
      r    = 64'(deg) * DEG_TO_RAD_Q30;
      r2   = (r * r) >> 30;
      term = r;
      pos  = r;
      neg  = 0;
      for (int k = 1; k <= 7; k++) begin
         term = ((term * r2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      s = (pos > neg) ? pos - neg : 64'd0;
      return 32'((s + (64'd1 << (SINE_SHIFT - 1))) >> SINE_SHIFT);
   endfunction

   function automatic rsp_beat_type mix_wheels(input req_beat_type beat);
      int unsigned hd;
      int unsigned yw;
      int unsigned turned;
      int unsigned ang;
      int unsigned cmag;
      int unsigned smag;
      int unsigned base13;
      int unsigned base24;
      int unsigned herr;
      int unsigned spd;
      int          kp;
      int          kd;
      int          corr;
      int          quad;
      int          mag;
      bit          cneg;
      bit          sneg;
      bit          on_left;
      bit          on_right;
      int          sgn [WHEELS];
      int          pull [WHEELS];
      bit          flip [WHEELS];
      logic [DUTY_W-1:0] duty [WHEELS];
      rsp_beat_type res;
      hd  = beat.heading_deg;
      yw  = beat.yaw_deg;
      spd = beat.speed;
      if (hd > 360) hd = hd - 360;
      turned = hd + 45;
      if (turned > 360) turned = turned - 360;
      ang = (turned == 360) ? 0 : turned;
      if (yw >= 360) yw = yw - 360;

      if (ang <= 90) begin
         smag = quarter_sine(ang);       cmag = quarter_sine(90 - ang);
         sneg = 1'b0;                    cneg = 1'b0;
      end else if (ang <= 180) begin
         smag = quarter_sine(180 - ang); cmag = quarter_sine(ang - 90);
         sneg = 1'b0;                    cneg = 1'b1;
      end else if (ang <= 270) begin
         smag = quarter_sine(ang - 180); cmag = quarter_sine(270 - ang);
         sneg = 1'b1;                    cneg = 1'b1;
      end else begin
         smag = quarter_sine(360 - ang); cmag = quarter_sine(ang - 270);
         sneg = 1'b1;                    cneg = 1'b0;
      end
      if (cmag == 0) cneg = 1'b0;
      if (smag == 0) sneg = 1'b0;

      if (cmag >= smag) begin
         base13 = spd;
         base24 = (cmag == 0) ? 0 : 32'((64'(smag) * 64'(spd)) / 64'(cmag));
      end else begin
         base24 = spd;
         base13 = 32'((64'(cmag) * 64'(spd)) / 64'(smag));
      end

      herr = (yw < 180) ? yw : 360 - yw;
      kd = HEADING_D_GAIN * (int'(herr) - int'(last_heading_err));
      if (kd > int'(duty_ceiling)) kd = int'(duty_ceiling);
      kp = int'(herr * (duty_ceiling / P_SPLIT));
      if (kp > int'(duty_ceiling)) kp = int'(duty_ceiling);
      corr = kp + kd;

      on_left  = (yw > 1) && (yw <= 180);
      on_right = (yw > 180) && (yw < 359);
      quad = int'((turned - 1) / 90);
      sgn = '{0, 0, 0, 0};
      if ((quad == 0 && on_left) || (quad == 2 && on_right)) begin
         sgn = '{1, -1, -1, 1};
      end else if ((quad == 0 && on_right) || (quad == 2 && on_left)) begin
         sgn = '{-1, 1, 1, -1};
      end else if ((quad == 1 && on_left) || (quad == 3 && on_right)) begin
         sgn = '{-1, -1, 1, 1};
      end else if ((quad == 1 && on_right) || (quad == 3 && on_left)) begin
         sgn = '{1, 1, -1, -1};
      end

      pull[0] = int'(base13) + sgn[0] * corr;
      pull[1] = int'(base24) + sgn[1] * corr;
      pull[2] = int'(base13) + sgn[2] * corr;
      pull[3] = int'(base24) + sgn[3] * corr;
      for (int i = 0; i < WHEELS; i++) begin
         flip[i] = (pull[i] < 0);
         mag = flip[i] ? -pull[i] : pull[i];
         if (mag > int'(duty_ceiling)) mag = int'(duty_ceiling);
         duty[i] = DUTY_W'(mag);
      end

      res.duty_one   = duty[0];
      res.duty_two   = duty[1];
      res.duty_three = duty[2];
      res.duty_four  = duty[3];
      res.dir_one    = ~(flip[0] ^ cneg);
      res.dir_two    = flip[1] ^ sneg;
      res.dir_three  = flip[2] ^ cneg;
      res.dir_four   = flip[3] ^ sneg;
      last_heading_err = herr;
      return res;
   endfunction

   task automatic send_req(input int unsigned hd, input int unsigned spd, input int unsigned yw);
      req_beat_type beat;
      beat.heading_deg = DEG_W'(hd);
      beat.speed       = SPEED_W'(spd);
      beat.yaw_deg     = DEG_W'(yw);
      if (idle_en && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      pending_wheel_cmds.push_back(mix_wheels(beat));
   endtask

   task automatic send_wide();
      send_req($urandom_range(0, 511), $urandom_range(0, 2047), $urandom_range(0, 511));
   endtask

   task automatic send_in_range();
      send_req($urandom_range(0, 360), $urandom_range(0, 2047), $urandom_range(0, 359));
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_wheel_cmds.size() != 0);
   endtask

   task automatic write_ceiling(input int unsigned value);
      drain_all();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= DUTY_W'(value);
      @(posedge clock);
      duty_ceiling = value & 12'hFFF;
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_travel_directions();
      int unsigned hdg_list [10];
      hdg_list = '{0, 44, 45, 90, 135, 180, 225, 270, 315, 360};
      for (int i = 0; i < 10; i++) begin
         send_req(hdg_list[i], 2000, (i % 2 == 1) ? 200 : 30);
      end
   endtask

   task automatic test_yaw_folding();
      int unsigned yaw_list [10];
      yaw_list = '{0, 1, 2, 179, 180, 181, 358, 359, 360, 511};
      for (int i = 0; i < 10; i++) begin
         send_req(100, 1500, yaw_list[i]);
      end
   endtask

   task automatic test_field_extremes();
      send_req(511, 2047, 511);
      send_req(361, 0, 0);
      send_req(0, 0, 90);
      send_req(0, 1, 359);
   endtask

   task automatic test_ceiling_extremes();
      int unsigned ceil_list [6];
      ceil_list = '{0, 4095, 4000, 59, 60, 1};
      for (int i = 0; i < 6; i++) begin
         write_ceiling(ceil_list[i]);
         repeat (25) send_in_range();
         send_wide();
      end
   endtask

   task automatic test_backpressure();
      write_ceiling(1800);
      -> long_hold_start;
      repeat (16) send_wide();
   endtask

   task automatic test_drain_pause();
      repeat (20) send_in_range();
      drain_all();
      repeat (20) send_in_range();
   endtask

   task automatic test_random_traffic();
      int unsigned yaw_track;
      int unsigned pick;
      yaw_track = $urandom_range(0, 359);
      for (int phase = 0; phase < 8; phase++) begin
         write_ceiling($urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 600));
         idle_en = (phase % 3 != 2);
         for (int n = 0; n < 150; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               // slowly drifting yaw steps by -5 to +5 degrees between tracked beats
               yaw_track = (yaw_track + 355 + $urandom_range(0, 10)) % 360;
               send_req($urandom_range(0, 360), $urandom_range(0, 2047), yaw_track);
            end else if (pick < 9) begin
               send_in_range();
            end else begin
               send_wide();
            end
         end
      end
   endtask

   task automatic test_quiet_tail();
      idle_en = 1'b0;
      write_ceiling(4000);
      repeat (150) send_in_range();
   endtask

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         fail_count++;
         $display("%0t %s expected %0d actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_wheel_cmds.size() == 0) begin
            fail_count++;
            $display("%0t result beat with none expected, actual %h", $time, rsp_data);
         end else begin
            want_cmd = pending_wheel_cmds.pop_front();
            compare_field("duty_one",   want_cmd.duty_one,   rsp_data.duty_one);
            compare_field("duty_two",   want_cmd.duty_two,   rsp_data.duty_two);
            compare_field("duty_three", want_cmd.duty_three, rsp_data.duty_three);
            compare_field("duty_four",  want_cmd.duty_four,  rsp_data.duty_four);
            compare_field("dir_one",    want_cmd.dir_one,    rsp_data.dir_one);
            compare_field("dir_two",    want_cmd.dir_two,    rsp_data.dir_two);
            compare_field("dir_three",  want_cmd.dir_three,  rsp_data.dir_three);
            compare_field("dir_four",   want_cmd.dir_four,   rsp_data.dir_four);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         ready_gap = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (ready_gap > 0) begin
            ready_gap = ready_gap - 1;
         end else if (idle_en && $urandom_range(0, 7) == 0) begin
            ready_gap = $urandom_range(1, 4);
         end
         rsp_ready <= !hold_off && (ready_gap == 0);
      end
   end

   initial forever begin
      @(long_hold_start);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_travel_directions();
      test_yaw_folding();
      test_field_extremes();
      test_ceiling_extremes();
      test_backpressure();
      test_drain_pause();
      test_random_traffic();
      test_quiet_tail();
      drain_all();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
